/* design/bpfa_pkg.sv */
package bpfa_pkg;

   localparam int NUM_PAGES  = 4096;
   localparam int WORD_BITS  = 64;
   localparam int NUM_WORDS  = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_IDX_W = $clog2(NUM_WORDS);
   localparam int BIT_IDX_W  = $clog2(WORD_BITS);
   localparam int BIT_CNT_W  = BIT_IDX_W + 1;
   localparam int WIN_LEVELS = BIT_IDX_W + 1;
   localparam int PAGE_W     = 12;
   localparam int COUNT_W    = 13;

   localparam logic [COUNT_W-1:0] PAGE_LIMIT_RESET = COUNT_W'(4096);

   localparam logic [1:0] ACT_MARK_USED = 2'd0;
   localparam logic [1:0] ACT_MARK_FREE = 2'd1;
   localparam logic [1:0] ACT_ALLOC     = 2'd2;

   typedef struct packed {
      logic [1:0]         action;
      logic [PAGE_W-1:0]  start_page;
      logic [COUNT_W-1:0] page_count;
   } req_type;

   typedef struct packed {
      logic              ok;
      logic [PAGE_W-1:0] found_page;
   } rsp_type;

   typedef struct packed {
      logic [COUNT_W-1:0]    count;
      logic [WORD_IDX_W-1:0] last_word;
      logic [BIT_IDX_W-1:0]  last_bit;
   } scan_cfg_type;

   typedef struct packed {
      logic                  done;
      logic                  hit;
      logic [WORD_IDX_W-1:0] index;
      logic [PAGE_W-1:0]     start;
   } scan_status_type;

endpackage

/* design/bitmap_page_frame_allocator.sv */
// First-fit page frame allocator over a used/free bitmap, one bit per page.
// Requests arrive on the req_ channel as valid/stall beats: mark a run used,
// mark a run free, or allocate the lowest run of free pages below the limit.
// Every request gives exactly one rsp_ beat with ok and found_page; an unknown action gets ok low.
// The csr_ port writes page_limit; write it only while no request is open.
// The bitmap lives in a 64 x 64 RAM with a registered read.
// A mark reads each bitmap word it touches and writes it back with the run set or cleared.
// An allocation streams one bitmap word per cycle through the bpfa_scan search
// pipeline, then marks the found run used; the RAM read port sets that pace.
// One request is worked on at a time; the next is taken once the previous
// one has its result registered.
// After reset every page reads as used and page_limit is 4096. Per-word valid
// flops stand in for a fill of the RAM, so no clearing pass is needed.
// A stalled response holds its register; a finished request then waits in
// its result state until the response register frees up.
module bitmap_page_frame_allocator (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  bpfa_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output bpfa_pkg::rsp_type                rsp_data,
   input  logic                             csr_wr_en,
   input  logic [bpfa_pkg::COUNT_W-1:0]     csr_wr_data
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECODE = 3'd1;
   localparam logic [2:0] ST_MARK   = 3'd2;
   localparam logic [2:0] ST_SCAN   = 3'd3;
   localparam logic [2:0] ST_RESULT = 3'd4;

   logic [2:0]                      state_ff, state_in;
   bpfa_pkg::req_type               cur_ff, cur_in;
   logic [bpfa_pkg::COUNT_W-1:0]    page_limit_ff;
   logic [bpfa_pkg::WORD_IDX_W:0]   rw_ff, rw_in;
   logic [bpfa_pkg::WORD_IDX_W-1:0] last_ff, last_in;
   logic [bpfa_pkg::COUNT_W-1:0]    mk_s_ff, mk_s_in;
   logic [bpfa_pkg::COUNT_W-1:0]    mk_e1_ff, mk_e1_in;
   logic                            mk_used_ff, mk_used_in;
   logic                            res_ok_ff, res_ok_in;
   logic [bpfa_pkg::PAGE_W-1:0]     res_page_ff, res_page_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   bpfa_pkg::rsp_type               rsp_data_ff, rsp_data_in;

   logic [bpfa_pkg::NUM_WORDS-1:0]  valid_ff;
   logic                            v0_ff;
   logic [bpfa_pkg::WORD_IDX_W-1:0] w0_ff;
   logic                            vb_rd_ff;

   logic                            rd_issue;
   logic [bpfa_pkg::WORD_IDX_W-1:0] rd_addr;
   logic [bpfa_pkg::WORD_BITS-1:0]  ram_q;
   logic [bpfa_pkg::WORD_BITS-1:0]  word_q;
   logic                            ram_we;
   logic [bpfa_pkg::WORD_BITS-1:0]  ram_wd;
   logic [bpfa_pkg::WORD_BITS-1:0]  mark_mask;
   logic [bpfa_pkg::BIT_IDX_W-1:0]  mark_lo;
   logic [bpfa_pkg::BIT_IDX_W-1:0]  mark_hi;
   logic                            mark_done;

   logic [bpfa_pkg::COUNT_W-1:0]    eff_limit;
   logic [bpfa_pkg::COUNT_W-1:0]    lim_m1;
   logic [bpfa_pkg::COUNT_W-1:0]    dec_start;
   logic [bpfa_pkg::COUNT_W:0]      dec_end_raw;
   logic [bpfa_pkg::COUNT_W:0]      dec_end;
   logic [bpfa_pkg::COUNT_W-1:0]    dec_e1;
   logic [bpfa_pkg::COUNT_W-1:0]    hit_start;
   logic [bpfa_pkg::COUNT_W-1:0]    hit_e1;
   logic                            rsp_free;
   logic                            scan_flush;
   logic                            scan_fail;
   bpfa_pkg::scan_cfg_type          scan_cfg;
   bpfa_pkg::scan_status_type       scan_status;

   assign eff_limit = (page_limit_ff > bpfa_pkg::COUNT_W'(bpfa_pkg::NUM_PAGES)) ?
                      bpfa_pkg::COUNT_W'(bpfa_pkg::NUM_PAGES) : page_limit_ff;
   assign lim_m1    = eff_limit - 1'b1;

   assign dec_start   = bpfa_pkg::COUNT_W'(cur_ff.start_page);
   assign dec_end_raw = {1'b0, dec_start} + {1'b0, cur_ff.page_count};
   assign dec_end     = (dec_end_raw > {1'b0, eff_limit}) ? {1'b0, eff_limit} : dec_end_raw;
   assign dec_e1      = bpfa_pkg::COUNT_W'(dec_end - 1'b1);

   assign hit_start = bpfa_pkg::COUNT_W'(scan_status.start);
   assign hit_e1    = hit_start + cur_ff.page_count - 1'b1;

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   assign scan_cfg.count     = cur_ff.page_count;
   assign scan_cfg.last_word = last_ff;
   assign scan_cfg.last_bit  = lim_m1[bpfa_pkg::BIT_IDX_W-1:0];
   assign scan_flush         = state_ff != ST_SCAN;
   assign scan_fail          = scan_status.done && !scan_status.hit &&
                               (scan_status.index == last_ff);

   // Words never written since reset read as all used.
   assign word_q  = vb_rd_ff ? ram_q : '1;
   assign rd_addr = rw_ff[bpfa_pkg::WORD_IDX_W-1:0];

   always_comb begin
      mark_lo = (w0_ff == mk_s_ff[bpfa_pkg::PAGE_W-1:bpfa_pkg::BIT_IDX_W]) ?
                mk_s_ff[bpfa_pkg::BIT_IDX_W-1:0] : '0;
      mark_hi = (w0_ff == last_ff) ? mk_e1_ff[bpfa_pkg::BIT_IDX_W-1:0] : '1;
      mark_mask = ({bpfa_pkg::WORD_BITS{1'b1}} << mark_lo) &
                  ({bpfa_pkg::WORD_BITS{1'b1}} >>
                   (bpfa_pkg::BIT_IDX_W'(bpfa_pkg::WORD_BITS - 1) - mark_hi));
      ram_wd    = mk_used_ff ? (word_q | mark_mask) : (word_q & ~mark_mask);
      ram_we    = (state_ff == ST_MARK) && v0_ff;
      mark_done = ram_we && (w0_ff == last_ff);
   end

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      rw_in        = rw_ff;
      last_in      = last_ff;
      mk_s_in      = mk_s_ff;
      mk_e1_in     = mk_e1_ff;
      mk_used_in   = mk_used_ff;
      res_ok_in    = res_ok_ff;
      res_page_in  = res_page_ff;
      rd_issue     = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cur_in   = req_data;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            res_ok_in   = 1'b0;
            res_page_in = '0;
            case (cur_ff.action)
               bpfa_pkg::ACT_MARK_USED, bpfa_pkg::ACT_MARK_FREE: begin
                  res_ok_in  = 1'b1;
                  mk_used_in = cur_ff.action == bpfa_pkg::ACT_MARK_USED;
                  if (cur_ff.page_count == '0 || dec_start >= eff_limit) begin
                     state_in = ST_RESULT;
                  end else begin
                     mk_s_in  = dec_start;
                     mk_e1_in = dec_e1;
                     rw_in    = {1'b0, dec_start[bpfa_pkg::PAGE_W-1:bpfa_pkg::BIT_IDX_W]};
                     last_in  = dec_e1[bpfa_pkg::PAGE_W-1:bpfa_pkg::BIT_IDX_W];
                     state_in = ST_MARK;
                  end
               end
               bpfa_pkg::ACT_ALLOC: begin
                  if (cur_ff.page_count == '0 || eff_limit == '0) begin
                     state_in = ST_RESULT;
                  end else begin
                     rw_in    = '0;
                     last_in  = lim_m1[bpfa_pkg::PAGE_W-1:bpfa_pkg::BIT_IDX_W];
                     state_in = ST_SCAN;
                  end
               end
               default: begin
                  state_in = ST_RESULT;
               end
            endcase
         end
         ST_MARK: begin
            rd_issue = rw_ff <= {1'b0, last_ff};
            if (rd_issue) begin
               rw_in = rw_ff + 1'b1;
            end
            if (mark_done) begin
               state_in = ST_RESULT;
            end
         end
         ST_SCAN: begin
            rd_issue = (rw_ff <= {1'b0, last_ff}) && !scan_status.hit;
            if (rd_issue) begin
               rw_in = rw_ff + 1'b1;
            end
            if (scan_status.hit) begin
               mk_s_in     = hit_start;
               mk_e1_in    = hit_e1;
               mk_used_in  = 1'b1;
               rw_in       = {1'b0, hit_start[bpfa_pkg::PAGE_W-1:bpfa_pkg::BIT_IDX_W]};
               last_in     = hit_e1[bpfa_pkg::PAGE_W-1:bpfa_pkg::BIT_IDX_W];
               res_ok_in   = 1'b1;
               res_page_in = scan_status.start;
               state_in    = ST_MARK;
            end else if (scan_fail) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (rsp_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.ok         = res_ok_ff;
               rsp_data_in.found_page = res_page_ff;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         v0_ff         <= 1'b0;
         valid_ff      <= '0;
         page_limit_ff <= bpfa_pkg::PAGE_LIMIT_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         v0_ff        <= rd_issue;
         if (ram_we) begin
            valid_ff[w0_ff] <= 1'b1;
         end
         if (csr_wr_en) begin
            page_limit_ff <= csr_wr_data;
         end
      end
      cur_ff      <= cur_in;
      rw_ff       <= rw_in;
      last_ff     <= last_in;
      mk_s_ff     <= mk_s_in;
      mk_e1_ff    <= mk_e1_in;
      mk_used_ff  <= mk_used_in;
      res_ok_ff   <= res_ok_in;
      res_page_ff <= res_page_in;
      rsp_data_ff <= rsp_data_in;
      w0_ff       <= rd_addr;
      vb_rd_ff    <= valid_ff[rd_addr];
   end

   bpfa_ram #(
      .WIDTH(bpfa_pkg::WORD_BITS),
      .DEPTH(bpfa_pkg::NUM_WORDS)
   ) u_bitmap_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (w0_ff),
      .wr_data (ram_wd),
      .rd_en   (rd_issue),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   bpfa_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .flush    (scan_flush),
      .in_valid (v0_ff && (state_ff == ST_SCAN)),
      .in_index (w0_ff),
      .in_word  (word_q),
      .cfg      (scan_cfg),
      .status   (scan_status)
   );

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_write_only_in_mark: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_MARK) && (w0_ff <= last_ff))
      else $error("bitmap written outside a mark run");

   a_hit_below_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) && scan_status.hit |->
         ({1'b0, hit_start} + {1'b0, cur_ff.page_count}) <= {1'b0, eff_limit})
      else $error("allocated run reaches past the page limit");

   a_accept_to_decode: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == ST_DECODE)
      else $error("accepted request not decoded");

   a_result_not_lost: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("stalled response beat changed");
`endif

endmodule

/* design/bpfa_ram.sv */
module bpfa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/bpfa_scan.sv */
module bpfa_scan (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                flush,
   input  logic                                in_valid,
   input  logic [bpfa_pkg::WORD_IDX_W-1:0]     in_index,
   input  logic [bpfa_pkg::WORD_BITS-1:0]      in_word,
   input  bpfa_pkg::scan_cfg_type              cfg,
   output bpfa_pkg::scan_status_type           status
);

   logic [bpfa_pkg::WORD_BITS-1:0]  used_word;
   logic [bpfa_pkg::WORD_BITS-1:0]  high_mask;
   logic [bpfa_pkg::WORD_BITS-1:0]  win [bpfa_pkg::WIN_LEVELS];
   logic [bpfa_pkg::BIT_CNT_W-1:0]  low_free;
   logic [bpfa_pkg::BIT_CNT_W-1:0]  high_free;

   logic                            s1_v_ff;
   logic [bpfa_pkg::WORD_IDX_W-1:0] s1_idx_ff;
   logic [bpfa_pkg::WORD_BITS-1:0]  s1_win_ff [bpfa_pkg::WIN_LEVELS];
   logic [bpfa_pkg::BIT_CNT_W-1:0]  s1_lz_ff;
   logic [bpfa_pkg::BIT_CNT_W-1:0]  s1_hz_ff;

   logic [bpfa_pkg::WORD_BITS-1:0]  busy_win;
   logic [bpfa_pkg::WORD_BITS-1:0]  geq_mask;
   logic [bpfa_pkg::WORD_BITS-1:0]  hit_vec;
   logic [bpfa_pkg::BIT_IDX_W-1:0]  count_m1;

   logic                            s2_v_ff;
   logic [bpfa_pkg::WORD_IDX_W-1:0] s2_idx_ff;
   logic [bpfa_pkg::WORD_BITS-1:0]  s2_hit_ff;
   logic [bpfa_pkg::BIT_CNT_W-1:0]  s2_lz_ff;
   logic [bpfa_pkg::BIT_CNT_W-1:0]  s2_hz_ff;

   logic [bpfa_pkg::COUNT_W-1:0]    run_ff;
   logic [bpfa_pkg::COUNT_W-1:0]    run_in;
   logic [bpfa_pkg::COUNT_W:0]      sum_a;
   logic                            a_hit;
   logic                            b_any;
   logic [bpfa_pkg::BIT_IDX_W-1:0]  b_pos;
   logic [bpfa_pkg::COUNT_W-1:0]    word_base;
   logic [bpfa_pkg::COUNT_W-1:0]    start_a;
   logic [bpfa_pkg::COUNT_W-1:0]    start_b;

   // Pages at or above the limit in the last word count as used.
   always_comb begin
      high_mask = ~({bpfa_pkg::WORD_BITS{1'b1}} >>
                    (bpfa_pkg::BIT_IDX_W'(bpfa_pkg::WORD_BITS - 1) - cfg.last_bit));
      used_word = in_word | ((in_index == cfg.last_word) ? high_mask : '0);
      win[0] = used_word;
      for (int k = 1; k < bpfa_pkg::WIN_LEVELS; k++) begin
         win[k] = win[k-1] | (win[k-1] << (1 << (k - 1)));
      end
      low_free = bpfa_pkg::BIT_CNT_W'(bpfa_pkg::WORD_BITS);
      for (int i = bpfa_pkg::WORD_BITS - 1; i >= 0; i--) begin
         if (used_word[i]) begin
            low_free = bpfa_pkg::BIT_CNT_W'(i);
         end
      end
      high_free = bpfa_pkg::BIT_CNT_W'(bpfa_pkg::WORD_BITS);
      for (int i = 0; i < bpfa_pkg::WORD_BITS; i++) begin
         if (used_word[i]) begin
            high_free = bpfa_pkg::BIT_CNT_W'(bpfa_pkg::WORD_BITS - 1 - i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || flush) begin
         s1_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= in_valid;
      end
      s1_idx_ff <= in_index;
      s1_win_ff <= win;
      s1_lz_ff  <= low_free;
      s1_hz_ff  <= high_free;
   end

   // A used page anywhere in the count pages ending at a bit blocks that bit.
   always_comb begin
      logic [bpfa_pkg::BIT_CNT_W-1:0] shift;
      busy_win = '0;
      shift    = '0;
      for (int k = 0; k < bpfa_pkg::WIN_LEVELS; k++) begin
         if (cfg.count[k]) begin
            busy_win = busy_win | (s1_win_ff[k] << shift);
            shift    = shift + bpfa_pkg::BIT_CNT_W'(1 << k);
         end
      end
      count_m1 = bpfa_pkg::BIT_IDX_W'(cfg.count - 1'b1);
      geq_mask = {bpfa_pkg::WORD_BITS{1'b1}} << count_m1;
      if (cfg.count <= bpfa_pkg::COUNT_W'(bpfa_pkg::WORD_BITS)) begin
         hit_vec = ~busy_win & geq_mask;
      end else begin
         hit_vec = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || flush) begin
         s2_v_ff <= 1'b0;
      end else begin
         s2_v_ff <= s1_v_ff;
      end
      s2_idx_ff <= s1_idx_ff;
      s2_hit_ff <= hit_vec;
      s2_lz_ff  <= s1_lz_ff;
      s2_hz_ff  <= s1_hz_ff;
   end

   always_comb begin
      sum_a     = {1'b0, run_ff} + (bpfa_pkg::COUNT_W + 1)'(s2_lz_ff);
      a_hit     = sum_a >= {1'b0, cfg.count};
      b_any     = |s2_hit_ff;
      b_pos     = '0;
      for (int i = bpfa_pkg::WORD_BITS - 1; i >= 0; i--) begin
         if (s2_hit_ff[i]) begin
            b_pos = bpfa_pkg::BIT_IDX_W'(i);
         end
      end
      word_base = bpfa_pkg::COUNT_W'({s2_idx_ff, bpfa_pkg::BIT_IDX_W'(0)});
      start_a   = word_base - run_ff;
      start_b   = word_base + bpfa_pkg::COUNT_W'(b_pos) + 1'b1 - cfg.count;
      if (s2_lz_ff == bpfa_pkg::BIT_CNT_W'(bpfa_pkg::WORD_BITS)) begin
         run_in = run_ff + bpfa_pkg::COUNT_W'(bpfa_pkg::WORD_BITS);
      end else begin
         run_in = bpfa_pkg::COUNT_W'(s2_hz_ff);
      end
      status.done  = s2_v_ff;
      status.hit   = s2_v_ff && (a_hit || b_any);
      status.index = s2_idx_ff;
      status.start = a_hit ? start_a[bpfa_pkg::PAGE_W-1:0] : start_b[bpfa_pkg::PAGE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset || flush) begin
         run_ff <= '0;
      end else if (s2_v_ff) begin
         run_ff <= run_in;
      end
   end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 200;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   bpfa_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   bpfa_pkg::rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [bpfa_pkg::COUNT_W-1:0] csr_wr_data = '0;

   bpfa_pkg::req_type request_queue[$];
   bpfa_pkg::rsp_type awaited_responses[$];

   logic [bpfa_pkg::NUM_PAGES-1:0] frame_used = '1;
   logic [bpfa_pkg::COUNT_W-1:0] limit_shadow = bpfa_pkg::PAGE_LIMIT_RESET;

   logic req_took = 1'b0;
   logic rsp_took = 1'b0;
   bit gapless = 1'b0;
   bit hold_toggle = 1'b0;
   bit hold_seen = 1'b0;
   int send_gap = 0;
   int rsp_wait = 0;
   int hold_left = 0;
   int quiet_cycles = 0;
   int mismatches = 0;

   bitmap_page_frame_allocator DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void mark_frames(int start, int count, bit used, int lim);
      for (int i = 0; i < count; i++) begin
         if (start + i >= lim) break;
         frame_used[start + i] = used;
      end
   endfunction

   function automatic bpfa_pkg::rsp_type apply_frame_request(bpfa_pkg::req_type r);
      bpfa_pkg::rsp_type res;
      int lim;
      int run;
      int first;
      res = '0;
      lim = (limit_shadow > bpfa_pkg::NUM_PAGES) ? bpfa_pkg::NUM_PAGES : int'(limit_shadow);
      case (r.action)
         bpfa_pkg::ACT_MARK_USED, bpfa_pkg::ACT_MARK_FREE: begin
            mark_frames(r.start_page, r.page_count,
                        r.action == bpfa_pkg::ACT_MARK_USED, lim);
            res.ok = 1'b1;
         end
         bpfa_pkg::ACT_ALLOC: begin
            if (r.page_count != 0) begin
               run = 0;
               for (int p = 0; p < lim; p++) begin
                  if (frame_used[p]) begin
                     run = 0;
                  end else begin
                     run++;
                     if (run == int'(r.page_count)) begin
                        first = p + 1 - run;
                        mark_frames(first, run, 1'b1, lim);
                        res.ok = 1'b1;
                        res.found_page = bpfa_pkg::PAGE_W'(first);
                        break;
                     end
                  end
               end
            end
         end
         default: res = '0;
      endcase
      return res;
   endfunction

   function automatic bpfa_pkg::req_type random_request(int lim);
      bpfa_pkg::req_type r;
      int pick;
      int top;
      pick = $urandom_range(0, 99);
      top = (lim > bpfa_pkg::NUM_PAGES) ? bpfa_pkg::NUM_PAGES : lim;
      if (top == 0) top = 1;
      r.action = bpfa_pkg::ACT_MARK_USED;
      r.start_page = bpfa_pkg::PAGE_W'($urandom_range(0, top - 1));
      r.page_count = bpfa_pkg::COUNT_W'($urandom_range(1, 8));
      if (pick < 40) begin
         r.action = bpfa_pkg::ACT_ALLOC;
         r.start_page = bpfa_pkg::PAGE_W'($urandom);
         if ($urandom_range(0, 9) == 0) begin
            r.page_count = bpfa_pkg::COUNT_W'($urandom_range(9, 80));
         end
      end else if (pick < 65) begin
         r.action = bpfa_pkg::ACT_MARK_FREE;
         r.page_count = bpfa_pkg::COUNT_W'($urandom_range(1, 40));
      end else if (pick < 78) begin
         r.page_count = bpfa_pkg::COUNT_W'($urandom_range(1, 24));
      end else if (pick < 86) begin
         r.action = bpfa_pkg::ACT_MARK_FREE;
         r.page_count = bpfa_pkg::COUNT_W'($urandom_range(64, 1024));
      end else if (pick < 91) begin
         r.action = bpfa_pkg::ACT_ALLOC;
         r.page_count = bpfa_pkg::COUNT_W'($urandom_range(64, 4096));
      end else if (pick < 95) begin
         r.action = ACT_UNUSED;
         r.start_page = bpfa_pkg::PAGE_W'($urandom);
         r.page_count = bpfa_pkg::COUNT_W'($urandom);
      end else begin
         r.action = 2'($urandom);
         r.start_page = bpfa_pkg::PAGE_W'($urandom);
         r.page_count = bpfa_pkg::COUNT_W'($urandom);
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("%0t mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   task automatic push_req(logic [1:0] act, int start, int count);
      bpfa_pkg::req_type r;
      r.action = act;
      r.start_page = bpfa_pkg::PAGE_W'(start);
      r.page_count = bpfa_pkg::COUNT_W'(count);
      request_queue.push_back(r);
   endtask

   task automatic queue_random(int n, int lim);
      repeat (n) request_queue.push_back(random_request(lim));
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (request_queue.size() != 0 || req_valid || awaited_responses.size() != 0);
   endtask

   task automatic write_page_limit(int value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= bpfa_pkg::COUNT_W'(value);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // The driver keeps a beat on the bus until it is taken, then waits its drawn gap.
   always @(negedge clock) begin
      logic offer;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         offer = req_valid && !req_took;
         if (!offer) begin
            if (send_gap != 0) begin
               send_gap--;
            end else if (request_queue.size() != 0) begin
               req_data <= request_queue.pop_front();
               offer = 1'b1;
               send_gap = gapless ? 0 : $urandom_range(0, 15);
            end
         end
         req_valid <= offer;
      end
   end

   always @(negedge clock) begin
      if (hold_toggle != hold_seen) begin
         hold_seen = hold_toggle;
         hold_left = HOLD_CYCLES;
      end
      if (rsp_took) rsp_wait = gapless ? 0 : $urandom_range(0, 15);
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (rsp_wait != 0) begin
         rsp_stall <= 1'b1;
         if (rsp_valid || $urandom_range(0, 1) == 1) rsp_wait--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      bpfa_pkg::rsp_type want;
      if (reset) begin
         frame_used = '1;
         limit_shadow = bpfa_pkg::PAGE_LIMIT_RESET;
         req_took <= 1'b0;
         rsp_took <= 1'b0;
         quiet_cycles = 0;
      end else begin
         req_took <= req_valid && !req_stall;
         rsp_took <= rsp_valid && !rsp_stall;
         if (csr_wr_en) limit_shadow = csr_wr_data;
         if (req_valid && !req_stall) awaited_responses.push_back(apply_frame_request(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (awaited_responses.size() == 0) begin
               report_mismatch("unexpected beat, found_page", rsp_data.found_page, 0);
            end else begin
               want = awaited_responses.pop_front();
               if (rsp_data.ok !== want.ok) report_mismatch("ok", rsp_data.ok, want.ok);
               if (rsp_data.found_page !== want.found_page) begin
                  report_mismatch("found_page", rsp_data.found_page, want.found_page);
               end
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      push_req(bpfa_pkg::ACT_ALLOC, 0, 1);
      push_req(bpfa_pkg::ACT_ALLOC, 0, 0);
      push_req(ACT_UNUSED, 4095, 8191);
      push_req(bpfa_pkg::ACT_MARK_FREE, 0, 128);
      push_req(bpfa_pkg::ACT_ALLOC, 4095, 1);
      push_req(bpfa_pkg::ACT_ALLOC, 0, 3);
      push_req(bpfa_pkg::ACT_ALLOC, 0, 0);
      push_req(bpfa_pkg::ACT_MARK_FREE, 4095, 8191);
      push_req(bpfa_pkg::ACT_ALLOC, 0, 1);
      push_req(bpfa_pkg::ACT_MARK_FREE, 100, 0);
      push_req(bpfa_pkg::ACT_MARK_USED, 0, 0);
      push_req(bpfa_pkg::ACT_ALLOC, 0, 4096);
      push_req(bpfa_pkg::ACT_MARK_FREE, 0, 4096);
      push_req(bpfa_pkg::ACT_ALLOC, 0, 4096);
      push_req(bpfa_pkg::ACT_ALLOC, 0, 1);
      push_req(bpfa_pkg::ACT_MARK_FREE, 0, 8191);
      push_req(bpfa_pkg::ACT_MARK_USED, 2048, 4096);
      push_req(bpfa_pkg::ACT_ALLOC, 0, 2048);
      push_req(bpfa_pkg::ACT_ALLOC, 0, 1);
      push_req(bpfa_pkg::ACT_MARK_FREE, 63, 2);
      push_req(bpfa_pkg::ACT_ALLOC, 0, 2);
      push_req(bpfa_pkg::ACT_MARK_FREE, 4032, 64);
      push_req(bpfa_pkg::ACT_ALLOC, 0, 65);
      push_req(bpfa_pkg::ACT_ALLOC, 0, 64);
      push_req(bpfa_pkg::ACT_MARK_FREE, 0, 4096);
      wait_drained();

      queue_random(150, 4096);
      wait_drained();

      // A long response hold-off with back-to-back requests backs the block up.
      hold_toggle = !hold_toggle;
      gapless = 1'b1;
      queue_random(40, 4096);
      wait_drained();
      gapless = 1'b0;

      write_page_limit(64);
      queue_random(50, 64);
      wait_drained();
      write_page_limit(65);
      queue_random(50, 65);
      wait_drained();
      write_page_limit(0);
      queue_random(15, 0);
      wait_drained();
      write_page_limit(1);
      queue_random(25, 1);
      wait_drained();
      write_page_limit(8191);
      queue_random(50, 8191);
      wait_drained();
      begin
         int lim;
         lim = $urandom_range(2, 4095);
         write_page_limit(lim);
         queue_random(60, lim);
      end
      wait_drained();
      write_page_limit(4096);
      queue_random(40, 4096);
      wait_drained();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (awaited_responses.size() != 0) begin
         report_mismatch("beats never returned", 0, awaited_responses.size());
      end
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
